>>> src/base54_stream_decoder_top_defines.svh
// assertion macros for the base-54 stream decoder checker
// no dependencies; expects clk and rst_n in the scope where a macro is used
`ifndef BASE54_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE54_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define B54_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define B54_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/b54_pkg.sv
// shared types, constants and the symbol lookup for the base-54 stream decoder
// no dependencies
package b54_pkg;

    localparam int ALPHA_LEN = 54;
    localparam logic [8*ALPHA_LEN-1:0] ALPHABET =
        "GHIJKLMNOPQRSTUVWXYZghijklmnopqrstuvwxyz(),-.<>@[]^_{}";

    typedef logic [5:0] sym_t;

    localparam sym_t SYM_UNKNOWN = 6'd63;
    // parity covers the first symbol without its own parity bit (low bits of 0xfd)
    localparam sym_t PARITY_MASK = 6'h3d;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_CHAR   = 3'd1,
        ERR_SINGLE_OFF = 3'd2,
        ERR_PARITY     = 3'd3,
        ERR_BAD_THIRD  = 3'd4,
        ERR_DUAL_OFF   = 3'd5,
        ERR_UNEVEN_END = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_BYTE,
        EMIT_PAIR,
        EMIT_ERR
    } emit_t;

    typedef enum logic {
        CFG_ALLOW_SINGLE = 1'b0,
        CFG_ALLOW_DUAL   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       oob_bit;
        logic       oob_valid;
        err_t       error_code;
        logic       last;
    } result_t;

    function automatic sym_t b54_symbol(input logic [7:0] c);
        sym_t s;
        s = SYM_UNKNOWN;
        for (int i = 0; i < ALPHA_LEN; i++)
        begin
            if (ALPHABET[8*(ALPHA_LEN-1-i) +: 8] == c)
            begin
                s = 6'(i);
            end
        end
        return s;
    endfunction

endpackage

>>> src/base54_stream_decoder_top.sv
// base-54 stream decoder: characters in, decoded bytes or an error code out
// depends on b54_pkg
//
// One character transfer is taken every cycle while s_tready is high. Its results (none,
// one, or two for a completed dual group) are registered into a four-entry result queue
// that feeds the master side; s_tready drops only while that queue holds more than two
// results, so the input runs at one character per cycle as long as the output side keeps
// up. Any error sends one error result with tlast set, then the block swallows all input
// without results until reset. Configuration writes are taken every cycle.
module base54_stream_decoder_top
    import b54_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] mode (end of stream marker)
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [8] byte_valid, [9] oob_bit, [10] oob_valid,
    // [13:11] error_code, [15:14] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic   allow_single_reg, allow_dual_reg;
    phase_t phase_reg, phase_next;
    sym_t   first_reg, first_next;
    sym_t   second_reg, second_next;
    logic   halted_reg, halted_next;

    result_t            q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    logic        accept, pop;
    sym_t        sym;
    emit_t       emit;
    err_t        err;
    logic        parity_bad;
    logic [8:0]  single_sum;
    logic [16:0] dual_sum;
    result_t     res0, res1;
    logic [1:0]  push_n;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    result_t     head;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign pop       = m_tvalid && m_tready;

    assign sym        = b54_symbol(s_tdata);
    assign parity_bad = first_reg[1] != ((^(first_reg & PARITY_MASK)) ^ (^sym));
    assign single_sum = 9'(first_reg[5:3]) * 9'd54 + 9'(sym);
    assign dual_sum   = 17'(first_reg[5:1]) * 17'd2916 + 17'(second_reg) * 17'd54
                        + 17'(sym);

    // group decision for the current transfer
    always_comb
    begin
        emit = EMIT_NONE;
        err  = ERR_NONE;
        if (accept && !halted_reg)
        begin
            if (s_tuser)
            begin
                if (phase_reg != PH_FIRST)
                begin
                    emit = EMIT_ERR;
                    err  = ERR_UNEVEN_END;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        emit = EMIT_NONE;
                    end
                    PH_SECOND:
                    begin
                        if (first_reg == SYM_UNKNOWN || sym == SYM_UNKNOWN)
                        begin
                            emit = EMIT_ERR;
                            err  = ERR_BAD_CHAR;
                        end
                        else if (!first_reg[0])
                        begin
                            if (!allow_single_reg)
                            begin
                                emit = EMIT_ERR;
                                err  = ERR_SINGLE_OFF;
                            end
                            else if (parity_bad)
                            begin
                                emit = EMIT_ERR;
                                err  = ERR_PARITY;
                            end
                            else
                            begin
                                emit = EMIT_BYTE;
                            end
                        end
                    end
                    PH_THIRD:
                    begin
                        if (!allow_dual_reg)
                        begin
                            emit = EMIT_ERR;
                            err  = ERR_DUAL_OFF;
                        end
                        else if (sym == SYM_UNKNOWN)
                        begin
                            emit = EMIT_ERR;
                            err  = ERR_BAD_THIRD;
                        end
                        else
                        begin
                            emit = EMIT_PAIR;
                        end
                    end
                    default:
                    begin
                        emit = EMIT_NONE;
                    end
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        halted_next = halted_reg;
        if (emit == EMIT_ERR)
        begin
            halted_next = 1'b1;
        end
        else if (emit == EMIT_BYTE || emit == EMIT_PAIR)
        begin
            phase_next = PH_FIRST;
        end
        else if (accept && !halted_reg && !s_tuser)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    first_next = sym;
                    phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    second_next = sym;
                    phase_next  = PH_THIRD;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // results pushed into the queue
    always_comb
    begin
        res0   = '0;
        res1   = '0;
        push_n = 2'd0;
        case (emit)
            EMIT_BYTE:
            begin
                res0.data_byte  = single_sum[7:0];
                res0.byte_valid = 1'b1;
                res0.oob_bit    = first_reg[2];
                res0.oob_valid  = 1'b1;
                res0.last       = 1'b1;
                push_n          = 2'd1;
            end
            EMIT_PAIR:
            begin
                res0.data_byte  = dual_sum[15:8];
                res0.byte_valid = 1'b1;
                res1.data_byte  = dual_sum[7:0];
                res1.byte_valid = 1'b1;
                res1.last       = 1'b1;
                push_n          = 2'd2;
            end
            EMIT_ERR:
            begin
                res0.error_code = err;
                res0.last       = 1'b1;
                push_n          = 2'd1;
            end
            default:
            begin
                push_n = 2'd0;
            end
        endcase
    end

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + QPTR_W'(push_n);
    assign rd_ptr_next  = rd_ptr_reg + QPTR_W'(pop);
    assign count_next   = count_reg + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_single_reg <= 1'b1;
            allow_dual_reg   <= 1'b1;
            phase_reg        <= PH_FIRST;
            first_reg        <= '0;
            second_reg       <= '0;
            halted_reg       <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ALLOW_SINGLE: allow_single_reg <= cfg_data;
                    CFG_ALLOW_DUAL:   allow_dual_reg   <= cfg_data;
                    default:          allow_dual_reg   <= allow_dual_reg;
                endcase
            end
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            halted_reg <= halted_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (push_n != 2'd0 && wr_ptr_reg == QPTR_W'(i))
            begin
                q_reg[i] <= res0;
            end
            else if (push_n == 2'd2 && wr_ptr_plus1 == QPTR_W'(i))
            begin
                q_reg[i] <= res1;
            end
        end
    end

    assign head    = q_reg[rd_ptr_reg];
    assign m_tdata = {2'b00, head.error_code, head.oob_valid, head.oob_bit,
                      head.byte_valid, head.data_byte};
    assign m_tlast = head.last;

endmodule

>>> src/b54_checker.sv
// port-level checks for the base-54 stream decoder, bound to the top level
// depends on base54_stream_decoder_top_defines.svh
`include "base54_stream_decoder_top_defines.svh"

module b54_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic unused_inputs;
    assign unused_inputs = ^{s_tvalid, s_tready, s_tdata, s_tuser,
                             cfg_valid, cfg_ready, cfg_index, cfg_data};

    `B54_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    `B54_ASSERT_NOW(a_err_form, m_tvalid && m_tdata[13:11] != 3'd0,
        m_tlast && m_tdata[10:0] == 11'd0, "error result carries data or lacks last")

    `B54_ASSERT_NOW(a_oob_single, m_tvalid && m_tdata[10],
        m_tdata[8] && m_tlast, "oob flag outside a single mode byte")

    `B54_ASSERT_NOW(a_nobyte_err, m_tvalid && !m_tdata[8],
        m_tdata[13:11] != 3'd0, "result without byte and without error")

    `B54_ASSERT_NEXT(a_halt_quiet, m_tvalid && m_tready && m_tdata[13:11] != 3'd0,
        !m_tvalid, "result after an error transfer")

endmodule

bind base54_stream_decoder_top b54_checker u_b54_checker (.*);

>>> tb/tb_base54_stream_decoder_top.sv
`timescale 1ns / 100ps
// self-checking testbench for base54_stream_decoder_top: random well-formed groups, one error
// per run, result-order prediction kept in a small tracker class; depends on b54_pkg

module tb_base54_stream_decoder_top;
    import b54_pkg::*;

    localparam int RADIX       = 54;
    localparam int HOLD_CYCLES = 160;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tuser;   // [0] end of stream marker
    logic        m_tvalid;
    logic        m_tready;
    // [7:0] data_byte, [8] byte_valid, [9] oob_bit, [10] oob_valid, [13:11] error_code
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic        cfg_data;

    bit idle_en;
    bit stall_req;
    int holds_done;
    int n_chars;
    int n_marks;
    int n_single;
    int n_dual;

    class decode_tracker;
        bit      single_en;
        bit      dual_en;
        bit      halted;
        phase_t  phase;
        sym_t    first_sym;
        sym_t    second_sym;
        sym_t    sym_of_code[256];
        result_t owed_q[$];
        int      results_seen;
        int      mismatches;

        function new();
            int c;
            int i;
            for (c = 0; c < 256; c++)
            begin
                sym_of_code[c] = SYM_UNKNOWN;
            end
            for (i = 0; i < ALPHA_LEN; i++)
            begin
                sym_of_code[ALPHABET[8*(ALPHA_LEN-1-i) +: 8]] = sym_t'(i);
            end
            single_en  = 1'b1;
            dual_en    = 1'b1;
            halted     = 1'b0;
            phase      = PH_FIRST;
            first_sym  = '0;
            second_sym = '0;
        endfunction

        function void write_reg(cfg_index_t idx, bit value);
            if (idx == CFG_ALLOW_SINGLE)
            begin
                single_en = value;
            end
            else
            begin
                dual_en = value;
            end
        endfunction

        function void owe(logic [7:0] b, bit bv, bit ob, bit ov, err_t e, bit l);
            result_t r;
            r.data_byte  = b;
            r.byte_valid = bv;
            r.oob_bit    = ob;
            r.oob_valid  = ov;
            r.error_code = e;
            r.last       = l;
            owed_q.push_back(r);
        endfunction

        // any error: one error result, then nothing until reset
        function void trip(err_t e);
            halted = 1'b1;
            owe(8'h00, 1'b0, 1'b0, 1'b0, e, 1'b1);
        endfunction

        function void take_char(bit eos, logic [7:0] code);
            sym_t s;
            int   sum;
            if (halted)
            begin
                return;
            end
            if (eos)
            begin
                if (phase != PH_FIRST)
                begin
                    trip(ERR_UNEVEN_END);
                end
                return;
            end
            s = sym_of_code[code];
            case (phase)
                PH_FIRST:
                begin
                    first_sym = s;
                    phase     = PH_SECOND;
                end
                PH_SECOND:
                begin
                    if (first_sym == SYM_UNKNOWN || s == SYM_UNKNOWN)
                    begin
                        trip(ERR_BAD_CHAR);
                    end
                    else if (first_sym[0])
                    begin
                        second_sym = s;
                        phase      = PH_THIRD;
                    end
                    else if (!single_en)
                    begin
                        trip(ERR_SINGLE_OFF);
                    end
                    else if (first_sym[1] != ^{first_sym & PARITY_MASK, s})
                    begin
                        trip(ERR_PARITY);
                    end
                    else
                    begin
                        sum = (first_sym >> 3) * RADIX + s;
                        owe(sum[7:0], 1'b1, first_sym[2], 1'b1, ERR_NONE, 1'b1);
                        phase = PH_FIRST;
                    end
                end
                default:
                begin
                    if (!dual_en)
                    begin
                        trip(ERR_DUAL_OFF);
                    end
                    else if (s == SYM_UNKNOWN)
                    begin
                        trip(ERR_BAD_THIRD);
                    end
                    else
                    begin
                        // value is truncated to 16 bits, high byte goes out first
                        sum = (first_sym >> 1) * RADIX * RADIX + second_sym * RADIX + s;
                        owe(sum[15:8], 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
                        owe(sum[7:0], 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b1);
                        phase = PH_FIRST;
                    end
                end
            endcase
        endfunction

        function void match_output(logic [15:0] tdata, logic tlast);
            result_t got;
            result_t want;
            got.data_byte  = tdata[7:0];
            got.byte_valid = tdata[8];
            got.oob_bit    = tdata[9];
            got.oob_valid  = tdata[10];
            got.error_code = err_t'(tdata[13:11]);
            got.last       = tlast;
            results_seen++;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: unexpected result byte %02h bv %0b oob %0b/%0b err %0d last %0b",
                             $realtime, got.data_byte, got.byte_valid, got.oob_bit,
                             got.oob_valid, got.error_code, got.last);
                end
                return;
            end
            want = owed_q.pop_front();
            if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
                got.oob_bit !== want.oob_bit || got.oob_valid !== want.oob_valid ||
                got.error_code !== want.error_code || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result %0d expected byte %02h bv %0b oob %0b/%0b err %0d last %0b",
                             $realtime, results_seen, want.data_byte, want.byte_valid,
                             want.oob_bit, want.oob_valid, want.error_code, want.last);
                    $display("%0t: result %0d got      byte %02h bv %0b oob %0b/%0b err %0d last %0b",
                             $realtime, results_seen, got.data_byte, got.byte_valid,
                             got.oob_bit, got.oob_valid, got.error_code, got.last);
                end
            end
        endfunction
    endclass

    decode_tracker trk;

    base54_stream_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] glyph(int sym);
        return ALPHABET[8*(ALPHA_LEN-1-sym) +: 8];
    endfunction

    function automatic bit is_glyph(logic [7:0] code);
        int i;
        for (i = 0; i < ALPHA_LEN; i++)
        begin
            if (glyph(i) == code)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // character outside the alphabet, NUL fairly often
    function automatic logic [7:0] stray_code();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
        begin
            return 8'h00;
        end
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_glyph(c));
        return c;
    endfunction

    // first symbol {hi, parity, 0} has to stay inside the alphabet
    function automatic bit single_fits(int hi, int lo, bit spoil);
        int p;
        p = ^{hi[3:0], lo[5:0]} ^ spoil;
        return (hi * 4 + 2 * p) <= ALPHA_LEN - 1;
    endfunction

    task automatic send_char(bit eos, logic [7:0] code);
        bit lowered;
        lowered = 1'b0;
        while (idle_en && $urandom_range(0, 99) < 14)
        begin
            if (!lowered)
            begin
                s_tvalid <= 1'b0;
                lowered = 1'b1;
            end
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= eos;
        s_tdata  <= code;
        do @(posedge clk); while (!s_tready);
        trk.take_char(eos, code);
        if (eos)
        begin
            n_marks++;
        end
        else
        begin
            n_chars++;
        end
        @(negedge clk);
    endtask

    task automatic send_sym(int sym);
        send_char(1'b0, glyph(sym));
    endtask

    task automatic send_single(int hi, int lo, bit spoil);
        int p;
        p = ^{hi[3:0], lo[5:0]} ^ spoil;
        send_sym(hi * 4 + 2 * p);
        send_sym(lo);
        n_single++;
    endtask

    task automatic send_dual(int a, int b, int c);
        send_sym(a);
        send_sym(b);
        send_sym(c);
        n_dual++;
    endtask

    // write both enables back to back, only while the decoder is idle
    task automatic set_modes(bit single_on, bit dual_on);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ALLOW_SINGLE;
        cfg_data  <= single_on;
        do @(posedge clk); while (!cfg_ready);
        trk.write_reg(CFG_ALLOW_SINGLE, single_on);
        @(negedge clk);
        cfg_index <= CFG_ALLOW_DUAL;
        cfg_data  <= dual_on;
        do @(posedge clk); while (!cfg_ready);
        trk.write_reg(CFG_ALLOW_DUAL, dual_on);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop offering, wait for every owed result, then let trailing items clear the pipe
    task automatic settle();
        s_tvalid <= 1'b0;
        while (trk.owed_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic random_traffic(int budget, bit single_ok, bit dual_ok);
        int start;
        int hi;
        int lo;
        bit pick_dual;
        start = n_chars;
        while (n_chars - start < budget)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_char(1'b1, 8'($urandom_range(0, 255)));
            end
            else
            begin
                pick_dual = dual_ok && (!single_ok || $urandom_range(0, 1) == 1);
                if (pick_dual)
                begin
                    send_dual(2 * $urandom_range(0, 26) + 1, $urandom_range(0, 53),
                              $urandom_range(0, 53));
                end
                else
                begin
                    do
                    begin
                        hi = $urandom_range(0, 13);
                        lo = $urandom_range(0, 53);
                    end
                    while (!single_fits(hi, lo, 1'b0));
                    send_single(hi, lo, 1'b0);
                end
            end
        end
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_armed;
        hold_left  = 0;
        hold_armed = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req && !hold_armed)
            begin
                hold_armed = 1'b1;
                hold_left  = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(idle_en && $urandom_range(0, 99) < 14);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            trk.match_output(m_tdata, m_tlast);
        end
    end

    initial
    begin
        #3_000_000;
        $display("timeout, %0d results still owed", trk.owed_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        err_t err_kind;
        int   hi;
        int   lo;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 1'b0;
        idle_en   = 1'b1;
        stall_req = 1'b0;
        trk       = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_modes(1'b1, 1'b1);

        // extremes of the alphabet, oob bit both ways, truncation of the dual value
        send_char(1'b1, 8'hff);
        send_char(1'b1, 8'h00);
        send_single(0, 0, 1'b0);
        send_single(12, 53, 1'b0);
        send_single(13, 1, 1'b0);
        send_single(1, 20, 1'b0);
        send_dual(1, 0, 0);
        send_dual(53, 53, 53);
        send_char(1'b1, 8'haa);
        send_dual(1, 53, 0);
        settle();

        idle_en = 1'b0;
        random_traffic(80, 1'b1, 1'b1);
        idle_en = 1'b1;
        random_traffic(140, 1'b1, 1'b1);
        settle();

        set_modes(1'b0, 1'b1);
        random_traffic(110, 1'b0, 1'b1);
        settle();

        set_modes(1'b1, 1'b0);
        random_traffic(110, 1'b1, 1'b0);
        settle();

        // both modes off: only markers between groups are harmless
        set_modes(1'b0, 1'b0);
        repeat (10) send_char(1'b1, 8'($urandom_range(0, 255)));
        settle();

        set_modes(1'b1, 1'b1);
        stall_req = 1'b1;
        random_traffic(180, 1'b1, 1'b1);
        settle();

        // one error per run, since it halts the decoder until reset
        err_kind = err_t'($urandom_range(1, 6));
        case (err_kind)
            ERR_BAD_CHAR:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    send_char(1'b0, stray_code());
                    send_char(1'b0, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    send_sym($urandom_range(0, 53));
                    send_char(1'b0, stray_code());
                end
            end
            ERR_SINGLE_OFF:
            begin
                set_modes(1'b0, 1'b1);
                do
                begin
                    hi = $urandom_range(0, 13);
                    lo = $urandom_range(0, 53);
                end
                while (!single_fits(hi, lo, 1'b0));
                send_single(hi, lo, 1'b0);
            end
            ERR_PARITY:
            begin
                do
                begin
                    hi = $urandom_range(0, 13);
                    lo = $urandom_range(0, 53);
                end
                while (!single_fits(hi, lo, 1'b1));
                send_single(hi, lo, 1'b1);
            end
            ERR_BAD_THIRD:
            begin
                send_sym(2 * $urandom_range(0, 26) + 1);
                send_sym($urandom_range(0, 53));
                send_char(1'b0, stray_code());
            end
            ERR_DUAL_OFF:
            begin
                set_modes(1'b1, 1'b0);
                send_sym(2 * $urandom_range(0, 26) + 1);
                send_sym($urandom_range(0, 53));
                send_char(1'b0, 8'($urandom_range(0, 255)));
            end
            default:
            begin
                send_sym(2 * $urandom_range(0, 26) + 1);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_sym($urandom_range(0, 53));
                end
                send_char(1'b1, 8'($urandom_range(0, 255)));
            end
        endcase

        // halted: every character is swallowed without results; register writes are still taken
        repeat (12) send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        settle();
        set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (6) send_sym($urandom_range(0, 53));
        settle();

        $display("covered %0d characters and %0d end markers: %0d single and %0d dual groups",
                 n_chars, n_marks, n_single, n_dual);
        $display("all four mode settings, %0d long hold-off, final error %s, %0d results checked",
                 holds_done, err_kind.name(), trk.results_seen);
        if (trk.mismatches == 0 && trk.owed_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     trk.mismatches, trk.owed_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
